### rtl/msp_pkg.sv
// Package with the types, codes and constants shared by the servo pulse generator.
package msp_pkg;

    localparam int PIN_W      = 8;
    localparam int COUNT_W    = 12;
    localparam int TICK_W     = 10;
    localparam int ANGLE_W    = 8;
    localparam int PULSE_W    = 16;
    localparam int PROD_W     = COUNT_W + TICK_W;
    localparam int MAG_W      = ANGLE_W + PULSE_W;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [TICK_W-1:0]  TICK_US_RST     = 10'd10;
    localparam logic [COUNT_W-1:0] FRAME_TICKS_RST = 12'd2000;
    localparam logic [ANGLE_W-1:0] MIN_ANGLE_RST   = 8'd0;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST   = 8'd180;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 16'd2500;

    typedef enum logic [2:0] {
        REG_TICK_US     = 3'd0,
        REG_FRAME_TICKS = 3'd1,
        REG_MIN_ANGLE   = 3'd2,
        REG_MAX_ANGLE   = 3'd3,
        REG_MIN_PULSE   = 3'd4,
        REG_MAX_PULSE   = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_ATTACH = 2'd2,
        ACT_DETACH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_MUL,
        ST_TICK_WALK,
        ST_MAP_PREP,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_MAP_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        action_t             action;
        logic [2:0]          channel;
        logic [ANGLE_W-1:0]  angle;
    } in_item_t;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             frame_start;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_us;
        logic [COUNT_W-1:0] frame_ticks;
        logic [ANGLE_W-1:0] min_angle;
        logic [ANGLE_W-1:0] max_angle;
        logic [PULSE_W-1:0] min_pulse_us;
        logic [PULSE_W-1:0] max_pulse_us;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [MAG_W-1:0]   dividend;
        logic [ANGLE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_rsp_t;

endpackage

### rtl/msp_apb_regs.sv
// Configuration register file of the servo pulse generator behind an APB-style port.
module msp_apb_regs
    import msp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_TICK_US:     cfg_next.tick_us      = pwdata[TICK_W-1:0];
                REG_FRAME_TICKS: cfg_next.frame_ticks  = pwdata[COUNT_W-1:0];
                REG_MIN_ANGLE:   cfg_next.min_angle    = pwdata[ANGLE_W-1:0];
                REG_MAX_ANGLE:   cfg_next.max_angle    = pwdata[ANGLE_W-1:0];
                REG_MIN_PULSE:   cfg_next.min_pulse_us = pwdata[PULSE_W-1:0];
                REG_MAX_PULSE:   cfg_next.max_pulse_us = pwdata[PULSE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TICK_US:     prdata = APB_DATA_W'(cfg_reg.tick_us);
            REG_FRAME_TICKS: prdata = APB_DATA_W'(cfg_reg.frame_ticks);
            REG_MIN_ANGLE:   prdata = APB_DATA_W'(cfg_reg.min_angle);
            REG_MAX_ANGLE:   prdata = APB_DATA_W'(cfg_reg.max_angle);
            REG_MIN_PULSE:   prdata = APB_DATA_W'(cfg_reg.min_pulse_us);
            REG_MAX_PULSE:   prdata = APB_DATA_W'(cfg_reg.max_pulse_us);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_us      <= TICK_US_RST;
            cfg_reg.frame_ticks  <= FRAME_TICKS_RST;
            cfg_reg.min_angle    <= MIN_ANGLE_RST;
            cfg_reg.max_angle    <= MAX_ANGLE_RST;
            cfg_reg.min_pulse_us <= MIN_PULSE_RST;
            cfg_reg.max_pulse_us <= MAX_PULSE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/msp_divider.sv
// Iterative restoring divider that produces one quotient bit per cycle for the angle map.
module msp_divider
    import msp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(MAG_W);

    logic                   run_reg,  run_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg,  cnt_next;
    logic [ANGLE_W-1:0]     rem_reg,  rem_next;
    logic [ANGLE_W-1:0]     dvs_reg,  dvs_next;
    logic [MAG_W-1:0]       quo_reg,  quo_next;
    logic [ANGLE_W:0]       shifted;
    logic                   fits;

    assign shifted = {rem_reg, quo_reg[MAG_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(MAG_W - 1);
            rem_next = '0;
            dvs_next = req.divisor;
            quo_next = req.dividend;
        end else if (run_reg) begin
            rem_next = fits ? ANGLE_W'(shifted - {1'b0, dvs_reg}) : shifted[ANGLE_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/msp_core.sv
// Sequencer and channel state of the servo pulse generator.
module msp_core
    import msp_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    output div_req_t  div_req,
    input  div_rsp_t  div_rsp
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [3:0] CH_COUNT = 4'(CHANNELS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    state_t               state_reg,   state_next;
    in_item_t             item_reg,    item_next;
    logic [COUNT_W-1:0]   count_reg,   count_next;
    logic                 started_reg, started_next;
    logic [CHANNELS-1:0]  active_reg,  active_next;
    logic [CHANNELS-1:0]  level_reg,   level_next;
    logic [PULSE_W-1:0]   pw_reg  [CHANNELS];
    logic [PULSE_W-1:0]   pw_next [CHANNELS];
    logic [CH_W-1:0]      idx_reg,     idx_next;
    logic [PROD_W-1:0]    prod_reg,    prod_next;
    logic [ANGLE_W-1:0]   num_reg,     num_next;
    logic [ANGLE_W-1:0]   den_reg,     den_next;
    logic [PULSE_W-1:0]   span_reg,    span_next;
    logic                 neg_reg,     neg_next;
    logic [MAG_W-1:0]     mag_reg,     mag_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg,  m_data_next;

    logic [COUNT_W:0]     count_inc;
    logic [ANGLE_W-1:0]   lo_angle, hi_angle, angle_c;
    logic [PIN_W-1:0]     levels_vec;
    logic [CH_W-1:0]      s_ch, item_ch;
    logic [PULSE_W:0]     map_sum;

    assign s_ch    = s_data.channel[CH_W-1:0];
    assign item_ch = item_reg.channel[CH_W-1:0];

    always_comb begin
        levels_vec = '0;
        levels_vec[CHANNELS-1:0] = level_reg;
    end

    always_comb begin
        count_inc = started_reg ? ({1'b0, count_reg} + 1'b1) : '0;
        if (count_inc >= {1'b0, cfg.frame_ticks}) begin
            count_inc = '0;
        end
        lo_angle = (cfg.min_angle < cfg.max_angle) ? cfg.min_angle : cfg.max_angle;
        hi_angle = (cfg.min_angle < cfg.max_angle) ? cfg.max_angle : cfg.min_angle;
        angle_c  = item_reg.angle;
        if (angle_c < lo_angle) begin
            angle_c = lo_angle;
        end
        if (angle_c > hi_angle) begin
            angle_c = hi_angle;
        end
        map_sum = neg_reg ? ({1'b0, cfg.min_pulse_us} - {1'b0, div_rsp.quotient[PULSE_W-1:0]})
                          : ({1'b0, cfg.min_pulse_us} + {1'b0, div_rsp.quotient[PULSE_W-1:0]});
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        count_next   = count_reg;
        started_next = started_reg;
        active_next  = active_reg;
        level_next   = level_reg;
        pw_next      = pw_reg;
        idx_next     = idx_reg;
        prod_next    = prod_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        span_next    = span_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = den_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_RESULT;
                    if (s_data.action == ACT_TICK) begin
                        count_next   = count_inc[COUNT_W-1:0];
                        started_next = 1'b1;
                        state_next   = ST_TICK_MUL;
                    end else if ({1'b0, s_data.channel} < CH_COUNT) begin
                        unique case (s_data.action)
                            ACT_WRITE: state_next = ST_MAP_PREP;
                            ACT_ATTACH: begin
                                active_next[s_ch] = 1'b1;
                                level_next[s_ch]  = 1'b0;
                                pw_next[s_ch]     = cfg.min_pulse_us;
                            end
                            ACT_DETACH: begin
                                active_next[s_ch] = 1'b0;
                                pw_next[s_ch]     = cfg.min_pulse_us;
                            end
                            default: state_next = ST_RESULT;
                        endcase
                    end
                end
            end
            ST_TICK_MUL: begin
                prod_next  = PROD_W'(count_reg) * PROD_W'(cfg.tick_us);
                idx_next   = '0;
                state_next = ST_TICK_WALK;
            end
            ST_TICK_WALK: begin
                if (active_reg[idx_reg]) begin
                    if (count_reg == '0) begin
                        level_next[idx_reg] = 1'b1;
                    end else if (prod_reg >= PROD_W'(pw_reg[idx_reg])) begin
                        level_next[idx_reg] = 1'b0;
                    end
                end
                if (idx_reg == CH_LAST) begin
                    state_next = ST_RESULT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MAP_PREP: begin
                if (cfg.min_angle <= cfg.max_angle) begin
                    num_next = angle_c - cfg.min_angle;
                    den_next = cfg.max_angle - cfg.min_angle;
                end else begin
                    num_next = cfg.min_angle - angle_c;
                    den_next = cfg.min_angle - cfg.max_angle;
                end
                neg_next  = cfg.max_pulse_us < cfg.min_pulse_us;
                span_next = neg_next ? (cfg.min_pulse_us - cfg.max_pulse_us)
                                     : (cfg.max_pulse_us - cfg.min_pulse_us);
                state_next = ST_MAP_MUL;
            end
            ST_MAP_MUL: begin
                if (den_reg == '0) begin
                    pw_next[item_ch] = cfg.min_pulse_us;
                    state_next       = ST_RESULT;
                end else begin
                    mag_next   = MAG_W'(num_reg) * MAG_W'(span_reg);
                    state_next = ST_MAP_DIV;
                end
            end
            ST_MAP_DIV: begin
                div_req.start = 1'b1;
                state_next    = ST_MAP_WAIT;
            end
            ST_MAP_WAIT: begin
                if (div_rsp.done) begin
                    pw_next[item_ch] = map_sum[PULSE_W-1:0];
                    state_next       = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.pin_levels  = levels_vec;
                    m_data_next.frame_start = (item_reg.action == ACT_TICK) && (count_reg == '0);
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            started_reg <= 1'b0;
            active_reg  <= '0;
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                pw_reg[k] <= MIN_PULSE_RST;
            end
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            started_reg <= started_next;
            active_reg  <= active_next;
            level_reg   <= level_next;
            m_valid_reg <= m_valid_next;
            pw_reg      <= pw_next;
        end
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        span_reg   <= span_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### rtl/multi_channel_servo_pulse_generator_top.sv
// Top level of the multi-channel servo pulse generator.
// Each item is a tick, an angle write, an attach or a detach, and each gives one result with
// the pin levels of all channels and a frame-start flag. The block takes one item at a time.
// A tick forms the frame-time product and then compares each channel in turn. An angle write
// uses the shared divider, which forms the 24 quotient bits of the angle-to-pulse map one
// bit per cycle. Attach, detach and non-tick items for a channel beyond CHANNELS go straight
// to the result. A finished result sits in an output register, so the next item is accepted
// while it waits to be taken.
module multi_channel_servo_pulse_generator_top
    import msp_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    msp_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    msp_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    msp_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule

### rtl/msp_checker.sv
// Port-level checker for the servo pulse generator and its bind to the top level.
module msp_checker
    import msp_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_clears_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result changed.");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Item accepted while the previous one is in work.");

    a_unused_pins_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pin_levels >> CHANNELS) == '0)
        else $error("Level driven on a channel that does not exist.");

endmodule

bind multi_channel_servo_pulse_generator_top msp_checker #(
    .CHANNELS (CHANNELS)
) u_msp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
